### design/ahfe_pkg.sv
// ----------------------------------------------------------------------------
// ahfe_pkg
// Shared types, constants and the CRC-16/X.25 byte update for the encoder.
// ----------------------------------------------------------------------------
package ahfe_pkg;

  localparam logic [7:0]  FLAG_BYTE = 8'h7E;
  localparam logic [7:0]  ESC_BYTE  = 8'h7D;
  localparam logic [7:0]  ESC_XOR   = 8'h20;
  localparam logic [15:0] CRC_POLY  = 16'h8408;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;

  // one classified item handed from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic        open;
    logic        last;
    logic [15:0] fcs;
  } ahfe_entry_t;

  typedef enum logic [4:0] {
    PH_OPEN  = 5'b00001,
    PH_DATA  = 5'b00010,
    PH_FLO   = 5'b00100,
    PH_FHI   = 5'b01000,
    PH_CLOSE = 5'b10000
  } ahfe_phase_t;

  // reflected CRC, one byte, LSB first
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### design/ahfe_if.sv
// ----------------------------------------------------------------------------
// ahfe_in_if / ahfe_out_if
// Valid/ready channels for payload items and encoded line items.
// ----------------------------------------------------------------------------
interface ahfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_last;

  modport source (output valid, output data_byte, output frame_last, input ready);
  modport sink   (input valid, input data_byte, input frame_last, output ready);
endinterface

interface ahfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, output out_byte, output run_last, output frame_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input frame_end,
                  output ready);
endinterface

### design/ahfe_front.sv
// ----------------------------------------------------------------------------
// ahfe_front
// Accepts payload items, tracks frame state, runs the CRC and classifies.
// ----------------------------------------------------------------------------
module ahfe_front import ahfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ahfe_in_if.sink     payload,
  output logic        push_valid,
  input  logic        push_ready,
  output ahfe_entry_t push_entry
);

  logic [15:0] crc;
  logic        in_frame;
  logic [15:0] crc_base;
  logic [15:0] crc_next;
  logic        accept;

  assign payload.ready = push_ready;
  assign push_valid    = payload.valid;
  assign accept        = payload.valid && push_ready;
  assign crc_base      = in_frame ? crc : CRC_INIT;
  assign crc_next      = crc_update(crc_base, payload.data_byte);

  always_comb begin
    push_entry.data = payload.data_byte;
    push_entry.open = !in_frame;
    push_entry.last = payload.frame_last;
    push_entry.fcs  = ~crc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc      <= CRC_INIT;
      in_frame <= 1'b0;
    end else if (accept) begin
      if (payload.frame_last) begin
        crc      <= CRC_INIT;
        in_frame <= 1'b0;
      end else begin
        crc      <= crc_next;
        in_frame <= 1'b1;
      end
    end
  end

endmodule

### design/ahfe_fifo.sv
// ----------------------------------------------------------------------------
// ahfe_fifo
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module ahfe_fifo import ahfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_ready,
  input  ahfe_entry_t push_entry,
  output logic        pop_valid,
  input  logic        pop,
  output ahfe_entry_t pop_entry
);

  ahfe_entry_t slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_entry  = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (pop)     rd_ptr <= ~rd_ptr;
      case ({do_push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/ahfe_back.sv
// ----------------------------------------------------------------------------
// ahfe_back
// Expands one queued item into line bytes, one per cycle while the line is not stalled, with escaping.
// ----------------------------------------------------------------------------
module ahfe_back import ahfe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        pop_valid,
  output logic        pop,
  input  ahfe_entry_t pop_entry,
  ahfe_out_if.source  line
);

  ahfe_entry_t entry;
  logic        loaded;
  ahfe_phase_t phase;
  logic        esc_hi;

  ahfe_phase_t phase_next;
  logic        esc_hi_next;
  logic [7:0]  cur;
  logic [7:0]  step_byte;
  logic        step_end;
  logic        finish;
  logic        room;
  logic        advance;

  assign room    = !line.valid || line.ready;
  assign advance = loaded && room;
  assign pop     = pop_valid && (!loaded || (advance && finish));

  always_comb begin
    case (phase)
      PH_FLO:  cur = entry.fcs[7:0];
      PH_FHI:  cur = entry.fcs[15:8];
      default: cur = entry.data;
    endcase
  end

  always_comb begin
    step_byte   = FLAG_BYTE;
    step_end    = 1'b0;
    finish      = 1'b0;
    phase_next  = phase;
    esc_hi_next = 1'b0;
    unique case (phase) inside
      PH_OPEN: begin
        phase_next = PH_DATA;
      end
      PH_DATA, PH_FLO, PH_FHI: begin
        if (!esc_hi && (cur == FLAG_BYTE || cur == ESC_BYTE)) begin
          step_byte   = ESC_BYTE;
          esc_hi_next = 1'b1;
        end else begin
          step_byte = esc_hi ? (cur ^ ESC_XOR) : cur;
          if (phase == PH_DATA) begin
            if (entry.last) phase_next = PH_FLO;
            else            finish     = 1'b1;
          end else if (phase == PH_FLO) begin
            phase_next = PH_FHI;
          end else begin
            phase_next = PH_CLOSE;
          end
        end
      end
      PH_CLOSE: begin
        step_end = 1'b1;
        finish   = 1'b1;
      end
      default: begin
        finish = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded     <= 1'b0;
      line.valid <= 1'b0;
      phase      <= PH_OPEN;
      esc_hi     <= 1'b0;
    end else begin
      if (room) line.valid <= loaded;
      if (pop) begin
        loaded <= 1'b1;
        phase  <= pop_entry.open ? PH_OPEN : PH_DATA;
        esc_hi <= 1'b0;
      end else if (advance && finish) begin
        loaded <= 1'b0;
      end else if (advance) begin
        phase  <= phase_next;
        esc_hi <= esc_hi_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) entry <= pop_entry;
    if (advance) begin
      line.out_byte  <= step_byte;
      line.run_last  <= finish;
      line.frame_end <= step_end;
    end
  end

endmodule

### design/async_hdlc_frame_encoder.sv
// ----------------------------------------------------------------------------
// async_hdlc_frame_encoder
// Async HDLC framing with CRC-16/X.25 and 0x7D/0x7E byte escaping.
// ----------------------------------------------------------------------------
// Each payload item produces 1 to 8 line items: an opening flag at frame start,
// the byte (two items if escaped), and on the frame's last byte the inverted
// CRC low byte first, escaped, then the closing flag marked by frame_end.
// run_last flags the final line item of each payload item. The back end emits
// one line byte per cycle while line.ready allows it. A plain mid-frame byte
// gives one line item, an escaped one two, a single-byte frame up to eight.
// The front computes the CRC in the accept cycle and takes new items while a
// two-entry queue has room, so input and output stall independently. Items
// pass the queue, then the back end's item register, then the output register.
module async_hdlc_frame_encoder import ahfe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ahfe_in_if.sink    payload,
  ahfe_out_if.source line
);

  logic        push_valid;
  logic        push_ready;
  ahfe_entry_t push_entry;
  logic        pop_valid;
  logic        pop;
  ahfe_entry_t pop_entry;

  ahfe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .payload    (payload),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  ahfe_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_entry  (pop_entry)
  );

  ahfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_entry (pop_entry),
    .line      (line)
  );

endmodule

### design/ahfe_checker.sv
// ----------------------------------------------------------------------------
// ahfe_checker
// Port-level checks on the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module ahfe_checker import ahfe_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       line_valid,
  input logic       line_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       frame_end
);

  // stalled line item holds
  assert property (@(posedge clk) disable iff (rst)
    line_valid && !line_ready |=> line_valid && $stable(out_byte) &&
      $stable(run_last) && $stable(frame_end))
    else $error("line item changed while stalled");

  // closing flag is a flag and ends its item's run
  assert property (@(posedge clk) disable iff (rst)
    line_valid && frame_end |-> out_byte == FLAG_BYTE && run_last)
    else $error("frame_end on a non-flag or mid-run item");

  // an escape byte never ends its item's run, so its partner follows
  assert property (@(posedge clk) disable iff (rst)
    line_valid && out_byte == ESC_BYTE |-> !run_last && !frame_end)
    else $error("escape byte ends a run");

  // nothing leaves the block right after reset
  assert property (@(posedge clk)
    $past(rst) |-> !line_valid)
    else $error("line valid right after reset");

endmodule

bind async_hdlc_frame_encoder ahfe_checker u_ahfe_checker (
  .clk        (clk),
  .rst        (rst),
  .line_valid (line.valid),
  .line_ready (line.ready),
  .out_byte   (line.out_byte),
  .run_last   (line.run_last),
  .frame_end  (line.frame_end)
);
